### rtl/core/iuc_pkg.sv
`default_nettype none

package iuc_pkg;

  // Field widths
  localparam int FRAME_W = 13;
  localparam int SRC_W   = 11;
  localparam int SXY_W   = 10;
  localparam int COORD_W = 12;
  localparam int COLOR_W = 32;
  localparam int POS_W   = 16;  // signed placement math, enough for scale up to 8

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd3;

  // Configuration register reset values
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST   = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST  = 13'd480;
  localparam logic [SRC_W-1:0]   SOURCE_WIDTH_RST  = 11'd320;
  localparam logic [SRC_W-1:0]   SOURCE_HEIGHT_RST = 11'd200;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
    logic [SRC_W-1:0]   source_width;
    logic [SRC_W-1:0]   source_height;
  } cfg_t;

  // Placed source pixel handed from front to back
  typedef struct packed {
    logic signed [POS_W-1:0] base_x;
    logic signed [POS_W-1:0] base_y;
    logic [COLOR_W-1:0]      colour;
  } work_t;

endpackage

`default_nettype wire

### rtl/core/iuc_front.sv
`default_nettype none

module iuc_front #(
  parameter int MAX_SCALE = 8,
  parameter int SCALE_W   = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire iuc_pkg::cfg_t                cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [iuc_pkg::SXY_W-1:0]    src_x_i,
  input  wire logic [iuc_pkg::SXY_W-1:0]    src_y_i,
  input  wire logic [iuc_pkg::COLOR_W-1:0]  colour_i,
  output logic                              push_o,
  output iuc_pkg::work_t                    work_o,
  output logic [SCALE_W-1:0]                scale_o,
  input  wire logic                         full_i
);

  localparam int PW   = iuc_pkg::POS_W;
  localparam int PROD_W = iuc_pkg::SRC_W + SCALE_W;

  logic [SCALE_W-1:0] scale_d, scale_q;
  logic               s1_valid_d, s1_valid_q;
  logic [iuc_pkg::SXY_W-1:0]   sx_q, sy_q;
  logic [iuc_pkg::COLOR_W-1:0] colour_q;
  logic               accept;

  logic [PROD_W-1:0]       fit_x_prod, fit_y_prod;
  logic [PW-1:0]           span_prod_x, span_prod_y;
  logic signed [PW-1:0]    span_x, span_y, adj_x, adj_y, off_x, off_y;
  logic [PW-1:0]           pos_x, pos_y;

  // Pick the largest scale that fits on both axes; no fit falls back to 1
  always_comb begin
    scale_d = SCALE_W'(1);
    fit_x_prod = '0;
    fit_y_prod = '0;
    for (int s = 1; s <= MAX_SCALE; s++) begin
      fit_x_prod = PROD_W'(s) * PROD_W'(cfg_i.source_width);
      fit_y_prod = PROD_W'(s) * PROD_W'(cfg_i.source_height);
      if (((cfg_i.source_width == '0) || (fit_x_prod <= PROD_W'(cfg_i.frame_width))) &&
          ((cfg_i.source_height == '0) || (fit_y_prod <= PROD_W'(cfg_i.frame_height)))) begin
        scale_d = SCALE_W'(s);
      end
    end
  end

  // Track the scale from the live configuration
  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
  end

  // Centering offset, halved with truncation toward zero
  always_comb begin
    span_prod_x = PW'(cfg_i.source_width) * PW'(scale_q);
    span_prod_y = PW'(cfg_i.source_height) * PW'(scale_q);
    span_x = $signed(PW'(cfg_i.frame_width)) - $signed(span_prod_x);
    span_y = $signed(PW'(cfg_i.frame_height)) - $signed(span_prod_y);
    adj_x  = span_x + $signed(PW'(span_x[PW-1]));
    adj_y  = span_y + $signed(PW'(span_y[PW-1]));
    off_x  = adj_x >>> 1;
    off_y  = adj_y >>> 1;
    pos_x  = PW'(sx_q) * PW'(scale_q);
    pos_y  = PW'(sy_q) * PW'(scale_q);
  end

  // Capture stage: take a word when empty or when the held one moves on
  assign in_stall_o = s1_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s1_valid_q && !full_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q     <= src_x_i;
      sy_q     <= src_y_i;
      colour_q <= colour_i;
    end
  end

  // Place the block origin
  assign work_o.base_x = off_x + $signed(pos_x);
  assign work_o.base_y = off_y + $signed(pos_y);
  assign work_o.colour = colour_q;
  assign scale_o       = scale_q;

endmodule

`default_nettype wire

### rtl/core/iuc_fifo.sv
`default_nettype none

module iuc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0] count_d, count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

### rtl/core/iuc_back.sv
`default_nettype none

module iuc_back #(
  parameter int MAX_SCALE = 8,
  parameter int SCALE_W   = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire iuc_pkg::cfg_t                 cfg_i,
  input  wire logic                          valid_i,
  input  wire iuc_pkg::work_t                work_i,
  input  wire logic [SCALE_W-1:0]            scale_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [iuc_pkg::COORD_W-1:0]        dest_x_o,
  output logic [iuc_pkg::COORD_W-1:0]        dest_y_o,
  output logic [iuc_pkg::COLOR_W-1:0]        pixel_value_o,
  output logic                               visible_o,
  output logic                               last_o
);

  localparam int PW    = iuc_pkg::POS_W;
  localparam int CW    = iuc_pkg::COORD_W;
  localparam int CNT_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic [CNT_W-1:0] i_d, i_q, j_d, j_q;
  logic             out_valid_d, out_valid_q;
  logic             out_free, fire, i_end, j_end, last;
  logic signed [PW-1:0] dx, dy;
  logic             vis_x, vis_y, vis;
  logic [CW-1:0]    dest_x_q, dest_y_q;
  logic [iuc_pkg::COLOR_W-1:0] pixel_q;
  logic             visible_q, last_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = valid_i && out_free;
  assign i_end    = (SCALE_W'(i_q) == scale_i - SCALE_W'(1));
  assign j_end    = (SCALE_W'(j_q) == scale_i - SCALE_W'(1));
  assign last     = i_end && j_end;
  assign pop_o    = fire && last;

  // Current write position and clipping
  always_comb begin
    dx    = work_i.base_x + $signed(PW'(i_q));
    dy    = work_i.base_y + $signed(PW'(j_q));
    vis_x = !dx[PW-1] && ($unsigned(dx) < PW'(cfg_i.frame_width)) &&
            (dx[PW-2:CW] == '0);
    vis_y = !dy[PW-1] && ($unsigned(dy) < PW'(cfg_i.frame_height)) &&
            (dy[PW-2:CW] == '0);
    vis   = vis_x && vis_y;
  end

  // Step column, then row, across the block
  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (fire) begin
      if (i_end) begin
        i_d = '0;
        j_d = j_end ? '0 : j_q + CNT_W'(1);
      end else begin
        i_d = i_q + CNT_W'(1);
      end
    end
    out_valid_d = out_free ? valid_i : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the output word
  always_ff @(posedge clk_i) begin
    if (fire) begin
      dest_x_q  <= vis ? dx[CW-1:0] : '0;
      dest_y_q  <= vis ? dy[CW-1:0] : '0;
      pixel_q   <= work_i.colour;
      visible_q <= vis;
      last_q    <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dest_x_o      = dest_x_q;
  assign dest_y_o      = dest_y_q;
  assign pixel_value_o = pixel_q;
  assign visible_o     = visible_q;
  assign last_o        = last_q;

  a_col_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (SCALE_W'(i_q) < scale_i) && (SCALE_W'(j_q) < scale_i))
    else $error("block counter beyond scale");
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (i_q == '0) && (j_q == '0)) else $error("counters not rewound");
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !visible_q) |-> (dest_x_q == '0) && (dest_y_q == '0))
    else $error("clipped write carries coordinates");

endmodule

`default_nettype wire

### rtl/core/integer_upscale_centering.sv
// Nearest-neighbour integer upscaler with centering.
// Input channel (in_valid_i / in_stall_o): one source pixel per word, its column,
// row and colour. Output channel (out_valid_o / out_stall_i): the frame writes
// of that pixel's scale x scale block, row by row, with visible_o low on writes
// that fall outside the frame and last_o high on the final write of the block.
// Configuration channel (cfg_valid_i / cfg_ready_o, always ready): register
// index and data; write only while no pixel is in flight.
// A pixel passes the front capture register, the queue and the output register.
// Each pixel yields scale*scale writes (1 to 64 at the default cap), which the
// back end emits one per cycle from its column/row counters unless the output
// stalls; a two-word queue lets the front take the next pixel meanwhile.
// Reset clears the queue and output register and loads the frame 640x480 and
// source 320x200 registers. A stalled output word holds until taken; the queue
// fills and then in_stall_o rises.
`default_nettype none

module integer_upscale_centering #(
  parameter int MAX_SCALE = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [iuc_pkg::FRAME_W-1:0]   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [iuc_pkg::SXY_W-1:0]     src_x_i,
  input  wire logic [iuc_pkg::SXY_W-1:0]     src_y_i,
  input  wire logic [iuc_pkg::COLOR_W-1:0]   colour_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [iuc_pkg::COORD_W-1:0]        dest_x_o,
  output logic [iuc_pkg::COORD_W-1:0]        dest_y_o,
  output logic [iuc_pkg::COLOR_W-1:0]        pixel_value_o,
  output logic                               visible_o,
  output logic                               last_o
);

  localparam int SCALE_W = $clog2(MAX_SCALE + 1);
  localparam int WORK_W  = $bits(iuc_pkg::work_t);
  localparam int Q_W     = WORK_W + SCALE_W;

  iuc_pkg::cfg_t cfg_d, cfg_q;
  logic          push, full, q_valid, pop;
  iuc_pkg::work_t     front_work, back_work;
  logic [SCALE_W-1:0] front_scale, back_scale;
  logic [Q_W-1:0]     q_in, q_out;

  assign cfg_ready_o = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        iuc_pkg::CFG_FRAME_WIDTH:   cfg_d.frame_width   = cfg_data_i;
        iuc_pkg::CFG_FRAME_HEIGHT:  cfg_d.frame_height  = cfg_data_i;
        iuc_pkg::CFG_SOURCE_WIDTH:  cfg_d.source_width  = cfg_data_i[iuc_pkg::SRC_W-1:0];
        iuc_pkg::CFG_SOURCE_HEIGHT: cfg_d.source_height = cfg_data_i[iuc_pkg::SRC_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= iuc_pkg::FRAME_WIDTH_RST;
      cfg_q.frame_height  <= iuc_pkg::FRAME_HEIGHT_RST;
      cfg_q.source_width  <= iuc_pkg::SOURCE_WIDTH_RST;
      cfg_q.source_height <= iuc_pkg::SOURCE_HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  iuc_front #(
    .MAX_SCALE(MAX_SCALE),
    .SCALE_W  (SCALE_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .src_x_i   (src_x_i),
    .src_y_i   (src_y_i),
    .colour_i  (colour_i),
    .push_o    (push),
    .work_o    (front_work),
    .scale_o   (front_scale),
    .full_i    (full)
  );

  assign q_in       = {front_work, front_scale};
  assign back_work  = q_out[Q_W-1:SCALE_W];
  assign back_scale = q_out[SCALE_W-1:0];

  iuc_fifo #(
    .WIDTH(Q_W),
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .data_o (q_out)
  );

  iuc_back #(
    .MAX_SCALE(MAX_SCALE),
    .SCALE_W  (SCALE_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .valid_i      (q_valid),
    .work_i       (back_work),
    .scale_i      (back_scale),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dest_x_o     (dest_x_o),
    .dest_y_o     (dest_y_o),
    .pixel_value_o(pixel_value_o),
    .visible_o    (visible_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
